/* hw/rtl/cpvf_pkg.sv */
// Shared types and constants of the cam phase velocity filter.
// Holds the sequencer states, register indexes and the divider request and response.
// No dependencies.
package cpvf_pkg;

	localparam int FIELD_W = 16;
	localparam int VEL_W   = 14;
	localparam int MEM_W   = 32;
	localparam int Q16_SHIFT = 16;

	localparam int VEL_MAX        = 5333;
	localparam int LIM_NUM        = 2667;
	localparam int LIM_DEN_PERIOD = 156250;
	localparam int LIM_DEN_TOOTH  = 64000;
	localparam int SCALE_PERIOD   = 312500;
	localparam int SCALE_TOOTH    = 128000;

	// Shared divider: quotient known to stay below 2**DIV_QUO_W.
	localparam int DIV_NUM_W = 35;
	localparam int DIV_QUO_W = 17;
	localparam int DIV_DEN_W = DIV_NUM_W - DIV_QUO_W + 1;
	localparam int DIV_CNT_W = $clog2(DIV_QUO_W + 1);

	localparam logic [1:0] REG_PERIOD_MODE = 2'd0;
	localparam logic [1:0] REG_TAU_FIRST   = 2'd1;
	localparam logic [1:0] REG_TAU_SECOND  = 2'd2;
	localparam logic [1:0] REG_SPEED_LIMIT = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VEL_CHECK,
		ST_VEL_START,
		ST_VEL_WAIT,
		ST_STAGE,
		ST_GAIN_START,
		ST_GAIN_WAIT,
		ST_MUL,
		ST_ACC,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_QUO_W-1:0] quot;
	} div_rsp_t;

endpackage

/* hw/rtl/cam_phase_velocity_filter_core.sv */
// Cam phase velocity filter: top level with sequencer, filter datapath and output register.
// Depends on cpvf_pkg and instantiates the shared divider cpvf_div.
// Compute item: after the input transfer come the velocity check and divide, then each filter
// stage in turn (active or bypassed), then the output load; an invalidate goes straight to the load.
// The input stays stalled until the cycle after the result loads, so a new item waits for the last.
// Reset clears the velocity state and the filter memories and sets speed_limit to all ones.
module cam_phase_velocity_filter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_write,
	input  logic [1:0]                          cfg_index,
	input  logic [cpvf_pkg::FIELD_W-1:0]        cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic [cpvf_pkg::FIELD_W-1:0]        position,
	input  logic [cpvf_pkg::FIELD_W-1:0]        prev_position,
	input  logic [cpvf_pkg::FIELD_W-1:0]        engine_period,
	input  logic [cpvf_pkg::FIELD_W-1:0]        tooth_time,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [cpvf_pkg::VEL_W-1:0]   raw_velocity,
	output logic signed [cpvf_pkg::VEL_W-1:0]   filtered_velocity,
	output logic                                out_of_range
);
	import cpvf_pkg::*;

	localparam int DIFF_W  = FIELD_W + 1;
	localparam int DELTA_W = MEM_W + 1;
	localparam int PROD_W  = DELTA_W + DIV_QUO_W + 1;
	localparam int LIM_W   = 34;
	localparam int SCALE_W = 19;

	// Truncate a Q16 value toward zero and clamp it to the velocity range.
	function automatic logic signed [VEL_W-1:0] q16_to_vel(input logic signed [MEM_W-1:0] m);
		logic signed [MEM_W-1:0]           adj;
		logic signed [MEM_W-Q16_SHIFT-1:0] t;
		logic signed [VEL_W-1:0]           r;
		adj = m[MEM_W-1] ? m + MEM_W'((1 << Q16_SHIFT) - 1) : m;
		t   = adj[MEM_W-1:Q16_SHIFT];
		if (int'(t) > VEL_MAX) begin
			r = VEL_W'(VEL_MAX);
		end else if (int'(t) < -VEL_MAX) begin
			r = VEL_W'(-VEL_MAX);
		end else begin
			r = VEL_W'(t);
		end
		return r;
	endfunction

	// Configuration registers.
	logic               period_mode_q;
	logic [FIELD_W-1:0] tau1_q;
	logic [FIELD_W-1:0] tau2_q;
	logic [FIELD_W-1:0] speed_limit_q;

	// Architectural state.
	state_t                   state_q, state_d;
	logic                     vel_valid_q;
	logic signed [VEL_W-1:0]  held_q;
	logic signed [MEM_W-1:0]  mem1_q;
	logic signed [MEM_W-1:0]  mem2_q;
	logic                     stage_q;

	// Working registers of the current item.
	logic signed [DIFF_W-1:0]  diff_q;
	logic [FIELD_W-1:0]        divisor_q;
	logic [FIELD_W-1:0]        tooth_q;
	logic [DIV_QUO_W-1:0]      gain_q;
	logic signed [DELTA_W-1:0] delta_q;
	logic signed [PROD_W-1:0]  prod_q;

	// Output register.
	logic                     out_valid_q;
	logic signed [VEL_W-1:0]  raw_out_q;
	logic signed [VEL_W-1:0]  filt_out_q;
	logic                     oor_out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                      in_fire;
	logic                      out_free;
	logic                      load_out;
	logic signed [DIFF_W-1:0]  diff_d;
	logic [DIFF_W-1:0]         diff_abs;
	logic [FIELD_W-1:0]        mag;
	logic [LIM_W-1:0]          lim_lhs;
	logic [LIM_W-1:0]          lim_rhs;
	logic                      over_limit;
	logic                      sat_taken;
	logic signed [VEL_W-1:0]   sat_vel;
	logic [SCALE_W-1:0]        scale;
	logic [DIV_NUM_W-1:0]      vel_num;
	logic signed [VEL_W-1:0]   div_mag;
	logic signed [VEL_W-1:0]   div_vel;
	logic [FIELD_W-1:0]        tau_sel;
	logic signed [VEL_W-1:0]   s1_vel;
	logic signed [VEL_W-1:0]   stage_in;
	logic signed [MEM_W-1:0]   stage_in_q16;
	logic signed [MEM_W-1:0]   mem_sel;
	logic signed [DELTA_W-1:0] delta_d;
	logic signed [PROD_W-1:0]  prod_adj;
	logic signed [DELTA_W+1:0] mem_sum;
	logic signed [MEM_W-1:0]   mem_new;
	logic signed [VEL_W-1:0]   filt_now;
	logic [VEL_W-1:0]          filt_abs;

	cpvf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// The phase difference is formed at the input transfer.
	assign diff_d = $signed({1'b0, position}) - $signed({1'b0, prev_position});

	// Velocity range check: |diff| > floor(2667*d/K) is the same as
	// |diff|*K > 2667*d for an integer |diff|, so no division is needed.
	assign diff_abs   = diff_q[DIFF_W-1] ? DIFF_W'(-diff_q) : DIFF_W'(diff_q);
	assign mag        = diff_abs[FIELD_W-1:0];
	assign lim_lhs    = period_mode_q ? LIM_W'(mag) * LIM_W'(LIM_DEN_PERIOD)
	                                  : LIM_W'(mag) * LIM_W'(LIM_DEN_TOOTH);
	assign lim_rhs    = LIM_W'(divisor_q) * LIM_W'(LIM_NUM);
	assign over_limit = lim_lhs > lim_rhs;
	assign sat_taken  = (divisor_q == '0) || over_limit;

	// A zero divisor saturates by diff >= 0, an overrange diff by diff > 0.
	// An overrange diff is never zero, so the sign bit decides both.
	assign sat_vel = diff_q[DIFF_W-1] ? VEL_W'(-VEL_MAX) : VEL_W'(VEL_MAX);

	// The division works on magnitudes; truncation toward zero follows
	// from negating the quotient afterwards.
	assign scale   = period_mode_q ? SCALE_W'(SCALE_PERIOD) : SCALE_W'(SCALE_TOOTH);
	assign vel_num = DIV_NUM_W'(mag) * DIV_NUM_W'(scale);
	assign div_mag = (div_rsp.quot > DIV_QUO_W'(VEL_MAX)) ? VEL_W'(VEL_MAX)
	                                                       : VEL_W'(div_rsp.quot);
	assign div_vel = diff_q[DIFF_W-1] ? -div_mag : div_mag;

	// Filter stage datapath, shared by both stages under stage_q.
	assign tau_sel      = stage_q ? tau2_q : tau1_q;
	assign s1_vel       = q16_to_vel(mem1_q);
	assign stage_in     = stage_q ? s1_vel : held_q;
	assign stage_in_q16 = $signed({{(MEM_W - Q16_SHIFT - VEL_W){stage_in[VEL_W-1]}},
	                               stage_in, {Q16_SHIFT{1'b0}}});
	assign mem_sel      = stage_q ? mem2_q : mem1_q;
	assign delta_d      = DELTA_W'(stage_in_q16) - DELTA_W'(mem_sel);

	// Scale the product back from Q16 with truncation toward zero.
	assign prod_adj = prod_q[PROD_W-1] ? prod_q + PROD_W'((1 << Q16_SHIFT) - 1) : prod_q;
	assign mem_sum  = (DELTA_W+2)'(mem_sel) + (DELTA_W+2)'(prod_adj[PROD_W-1:Q16_SHIFT]);
	assign mem_new  = mem_sum[MEM_W-1:0];

	// The filtered output always follows the second stage memory, also when
	// that stage is bypassed, because the bypass reloads it with the input.
	assign filt_now = q16_to_vel(mem2_q);
	assign filt_abs = filt_now[VEL_W-1] ? VEL_W'(-filt_now) : VEL_W'(filt_now);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (op) begin
						state_d = ST_OUT;
					end else if (vel_valid_q) begin
						state_d = ST_VEL_CHECK;
					end else begin
						state_d = ST_STAGE;
					end
				end
			end
			ST_VEL_CHECK: begin
				state_d = sat_taken ? ST_STAGE : ST_VEL_START;
			end
			ST_VEL_START: begin
				state_d = ST_VEL_WAIT;
			end
			ST_VEL_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_STAGE;
				end
			end
			ST_STAGE: begin
				if (tau_sel != '0) begin
					state_d = ST_GAIN_START;
				end else if (stage_q) begin
					state_d = ST_OUT;
				end
			end
			ST_GAIN_START: begin
				state_d = ST_GAIN_WAIT;
			end
			ST_GAIN_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_ACC;
			end
			ST_ACC: begin
				state_d = stage_q ? ST_OUT : ST_STAGE;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs: handshake and divider requests.
	always_comb begin
		in_stall      = 1'b1;
		load_out      = 1'b0;
		div_req.start = 1'b0;
		div_req.num   = DIV_NUM_W'({tooth_q, {Q16_SHIFT{1'b0}}});
		div_req.den   = DIV_DEN_W'({tau_sel, 2'b00}) + DIV_DEN_W'(tooth_q);
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_VEL_START: begin
				div_req.start = 1'b1;
				div_req.num   = vel_num;
				div_req.den   = DIV_DEN_W'(divisor_q);
			end
			ST_GAIN_START: begin
				// gain = tooth*65536 / (4*tau + tooth); a zero tooth time
				// gives a zero gain without a special case.
				div_req.start = 1'b1;
			end
			ST_OUT: begin
				load_out = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_mode_q <= 1'b0;
			tau1_q        <= '0;
			tau2_q        <= '0;
			speed_limit_q <= '1;
			state_q       <= ST_IDLE;
			vel_valid_q   <= 1'b0;
			held_q        <= '0;
			mem1_q        <= '0;
			mem2_q        <= '0;
			stage_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_PERIOD_MODE: period_mode_q <= cfg_data[0];
					REG_TAU_FIRST:   tau1_q        <= cfg_data;
					REG_TAU_SECOND:  tau2_q        <= cfg_data;
					REG_SPEED_LIMIT: speed_limit_q <= cfg_data;
				endcase
			end

			state_q <= state_d;

			if (in_fire) begin
				// A compute step leaves the flag set, an invalidate clears it.
				vel_valid_q <= !op;
				stage_q     <= 1'b0;
			end

			if (state_q == ST_VEL_CHECK && sat_taken) begin
				held_q <= sat_vel;
			end
			if (state_q == ST_VEL_WAIT && div_rsp.done) begin
				held_q <= div_vel;
			end

			// A bypassed stage passes its input and reloads its memory.
			if (state_q == ST_STAGE && tau_sel == '0) begin
				if (stage_q) begin
					mem2_q <= stage_in_q16;
				end else begin
					mem1_q  <= stage_in_q16;
					stage_q <= 1'b1;
				end
			end
			if (state_q == ST_ACC) begin
				if (stage_q) begin
					mem2_q <= mem_new;
				end else begin
					mem1_q  <= mem_new;
					stage_q <= 1'b1;
				end
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working and output payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			diff_q    <= diff_d;
			divisor_q <= period_mode_q ? engine_period : tooth_time;
			tooth_q   <= tooth_time;
		end
		if (state_q == ST_GAIN_WAIT && div_rsp.done) begin
			gain_q  <= div_rsp.quot;
			delta_q <= delta_d;
		end
		if (state_q == ST_MUL) begin
			prod_q <= delta_q * $signed({1'b0, gain_q});
		end
		if (load_out) begin
			raw_out_q  <= held_q;
			filt_out_q <= filt_now;
			oor_out_q  <= FIELD_W'(filt_abs) > speed_limit_q;
		end
	end

	assign out_valid         = out_valid_q;
	assign raw_velocity      = raw_out_q;
	assign filtered_velocity = filt_out_q;
	assign out_of_range      = oor_out_q;

endmodule

/* hw/rtl/cpvf_div.sv */
// Shared restoring divider, one quotient bit per cycle.
// Depends on cpvf_pkg for widths and the request and response structs.
module cpvf_div (
	input  logic               clk,
	input  logic               arst_n,
	input  cpvf_pkg::div_req_t req,
	output cpvf_pkg::div_rsp_t rsp
);
	import cpvf_pkg::*;

	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_QUO_W-1:0] num_lo_q;
	logic [DIV_QUO_W-1:0] quot_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	// The caller guarantees the quotient fits, so the upper numerator bits
	// start out below the divisor.
	assign trial = {rem_q, num_lo_q[DIV_QUO_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= DIV_CNT_W'(DIV_QUO_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q    <= DIV_DEN_W'(req.num >> DIV_QUO_W);
			num_lo_q <= req.num[DIV_QUO_W-1:0];
			den_q    <= req.den;
		end else if (cnt_q != '0) begin
			rem_q    <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			num_lo_q <= num_lo_q << 1;
			quot_q   <= {quot_q[DIV_QUO_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule
